/* rtl/core/rrd_pkg.sv */
// ----------------------------------------------------------------------------
// Round-robin ring dispatcher package
// Shared widths, codes and parameter defaults for the dispatcher block.
// ----------------------------------------------------------------------------
package rrd_pkg;

	// Parameter defaults
	localparam int DEF_MAX_WORKERS = 8;
	localparam int DEF_RING_DEPTH  = 256;

	// Field widths
	localparam int CFG_W    = 4;
	localparam int HANDLE_W = 32;
	localparam int WORKER_W = 3;

	// Reset value of the workers-in-use register
	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	// Request modes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

endpackage

/* rtl/core/rrd_if.sv */
// ----------------------------------------------------------------------------
// Dispatcher channel interfaces
// Valid/ready channels for dispatch requests and their responses.
// ----------------------------------------------------------------------------

// Request channel: push a handle or pop from a named ring
interface rrd_req_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [rrd_pkg::HANDLE_W-1:0]  handle_in;
	logic [rrd_pkg::WORKER_W-1:0]  pop_worker;

	modport source (output valid, mode, handle_in, pop_worker, input ready);
	modport sink   (input valid, mode, handle_in, pop_worker, output ready);
endinterface

// Response channel: one word for every request
interface rrd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [rrd_pkg::WORKER_W-1:0]  worker;
	logic [rrd_pkg::HANDLE_W-1:0]  handle_out;
	logic                          dropped;

	modport source (output valid, accepted, worker, handle_out, dropped, input ready);
	modport sink   (input valid, accepted, worker, handle_out, dropped, output ready);
endinterface

/* rtl/core/round_robin_ring_dispatcher.sv */
// ----------------------------------------------------------------------------
// Round-robin ring dispatcher
// Spreads handles over per-worker ring FIFOs and pops them back by worker.
// ----------------------------------------------------------------------------
// One request is handled at a time by a small sequencer around a single
// ring-check unit that examines one worker ring per cycle. A pop is accepted,
// then its pointer is checked and its slot read, and then its response word
// is loaded. A push is accepted, then wraps the round-robin pointer into the
// worker count if a reconfiguration left it at or above that count (normally
// not so), then examines from one ring up to all rings in use until one has
// room, and then loads its response word. The response cycle is stretched
// while the previous response word still waits to be taken. The response
// register lets a new request be accepted while that word waits.
// Ring contents have no reset; only the ring pointers do.
module round_robin_ring_dispatcher #(
	parameter int MAX_WORKERS = rrd_pkg::DEF_MAX_WORKERS,
	parameter int RING_DEPTH  = rrd_pkg::DEF_RING_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rrd_pkg::CFG_W-1:0]  cfg_wdata,
	rrd_req_if.sink                    req,
	rrd_rsp_if.source                  rsp
);

	// Derived widths
	localparam int WW      = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int CW      = $clog2(MAX_WORKERS + 1);
	localparam int XW      = (CW > rrd_pkg::CFG_W) ? CW : rrd_pkg::CFG_W;
	localparam int PW      = $clog2(RING_DEPTH);
	localparam int SLOTS   = MAX_WORKERS * RING_DEPTH;
	localparam int AW      = $clog2(SLOTS);

	localparam logic [PW-1:0] PTR_LAST  = PW'(RING_DEPTH - 1);
	localparam logic [AW-1:0] DEPTH_A   = AW'(RING_DEPTH);
	localparam logic [XW-1:0] MAX_X     = XW'(MAX_WORKERS);

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NORM = 3'd1;
	localparam logic [2:0] ST_SCAN = 3'd2;
	localparam logic [2:0] ST_POP  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]                      state_q;
	logic [rrd_pkg::CFG_W-1:0]       cfg_q;
	logic [WW-1:0]                   nw_q;
	logic [PW-1:0]                   rp_q [MAX_WORKERS];
	logic [PW-1:0]                   wp_q [MAX_WORKERS];

	logic [CW-1:0]                   n_q;
	logic [CW-1:0]                   cur_q;
	logic [CW-1:0]                   start_q;
	logic [CW-1:0]                   k_q;
	logic [rrd_pkg::HANDLE_W-1:0]    handle_q;
	logic                            in_range_q;

	logic                            res_acc_q;
	logic [rrd_pkg::WORKER_W-1:0]    res_wk_q;
	logic                            res_drop_q;
	logic                            res_hit_q;

	logic                            out_valid_q;
	logic                            out_acc_q;
	logic [rrd_pkg::WORKER_W-1:0]    out_wk_q;
	logic [rrd_pkg::HANDLE_W-1:0]    out_handle_q;
	logic                            out_drop_q;

	logic [XW-1:0]                   cfg_x;
	logic [XW-1:0]                   n_x;
	logic [XW-1:0]                   pw_x;
	logic [XW-1:0]                   cur_x;
	logic                            pw_ok;
	logic [WW-1:0]                   cur_w;
	logic [PW-1:0]                   rp_cur;
	logic [PW-1:0]                   wp_cur;
	logic [PW-1:0]                   rp_nx;
	logic [PW-1:0]                   wp_nx;
	logic                            ring_full;
	logic                            ring_empty;
	logic [CW-1:0]                   cur_inc;
	logic [CW-1:0]                   cur_wrap;
	logic [CW-1:0]                   start_inc;
	logic [CW-1:0]                   start_wrap;
	logic [AW-1:0]                   ring_base;
	logic                            take;
	logic                            load_out;
	logic                            mem_we;
	logic                            mem_re;
	logic [AW-1:0]                   mem_waddr;
	logic [AW-1:0]                   mem_raddr;
	logic [rrd_pkg::HANDLE_W-1:0]    mem_rdata;

	// Clamp the worker count and range-check the named ring
	always_comb begin
		cfg_x = XW'(cfg_q);
		if (cfg_x == '0) begin
			n_x = XW'(1);
		end else if (cfg_x > MAX_X) begin
			n_x = MAX_X;
		end else begin
			n_x = cfg_x;
		end
		pw_x  = XW'(req.pop_worker);
		pw_ok = (pw_x < n_x);
	end

	// Ring check unit: one ring per cycle
	always_comb begin
		cur_w      = cur_q[WW-1:0];
		cur_x      = XW'(cur_q);
		rp_cur     = rp_q[cur_w];
		wp_cur     = wp_q[cur_w];
		wp_nx      = (wp_cur == PTR_LAST) ? '0 : wp_cur + 1'b1;
		rp_nx      = (rp_cur == PTR_LAST) ? '0 : rp_cur + 1'b1;
		ring_full  = (wp_nx == rp_cur);
		ring_empty = (rp_cur == wp_cur);
		cur_inc    = cur_q + 1'b1;
		cur_wrap   = (cur_inc == n_q) ? '0 : cur_inc;
		start_inc  = start_q + 1'b1;
		start_wrap = (start_inc == n_q) ? '0 : start_inc;
		ring_base  = AW'(cur_w) * DEPTH_A;
	end

	assign take      = req.valid && req.ready;
	assign load_out  = (state_q == ST_FIN) && (!out_valid_q || rsp.ready);
	assign mem_we    = (state_q == ST_SCAN) && !ring_full;
	assign mem_re    = (state_q == ST_POP) && in_range_q && !ring_empty;
	assign mem_waddr = ring_base + AW'(wp_cur);
	assign mem_raddr = ring_base + AW'(rp_cur);

	// Hold the worker count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= rrd_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	// Sequencer and ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			nw_q    <= '0;
			for (int i = 0; i < MAX_WORKERS; i++) begin
				rp_q[i] <= '0;
				wp_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= (req.mode == rrd_pkg::MODE_POP) ? ST_POP : ST_NORM;
					end
				end
				ST_NORM: begin
					if (cur_q < n_q) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!ring_full) begin
						wp_q[cur_w] <= wp_nx;
						nw_q        <= cur_wrap[WW-1:0];
						state_q     <= ST_FIN;
					end else if (k_q == n_q - 1'b1) begin
						nw_q    <= start_wrap[WW-1:0];
						state_q <= ST_FIN;
					end
				end
				ST_POP: begin
					if (in_range_q && !ring_empty) begin
						rp_q[cur_w] <= rp_nx;
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request payload and scan registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (take) begin
					n_q        <= n_x[CW-1:0];
					handle_q   <= req.handle_in;
					in_range_q <= pw_ok;
					res_wk_q   <= req.pop_worker;
					res_acc_q  <= 1'b0;
					res_drop_q <= 1'b0;
					res_hit_q  <= 1'b0;
					if (req.mode == rrd_pkg::MODE_POP) begin
						cur_q <= pw_ok ? pw_x[CW-1:0] : '0;
					end else begin
						cur_q <= CW'(nw_q);
					end
				end
			end
			ST_NORM: begin
				// Wrap a stale pointer into the worker count
				if (cur_q >= n_q) begin
					cur_q <= cur_q - n_q;
				end else begin
					start_q <= cur_q;
					k_q     <= '0;
				end
			end
			ST_SCAN: begin
				if (!ring_full) begin
					res_acc_q <= 1'b1;
					res_wk_q  <= cur_x[rrd_pkg::WORKER_W-1:0];
				end else if (k_q == n_q - 1'b1) begin
					res_drop_q <= 1'b1;
					res_wk_q   <= '0;
				end else begin
					k_q   <= k_q + 1'b1;
					cur_q <= cur_wrap;
				end
			end
			ST_POP: begin
				if (in_range_q && !ring_empty) begin
					res_acc_q <= 1'b1;
					res_hit_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Response word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_acc_q    <= res_acc_q;
			out_wk_q     <= res_wk_q;
			out_handle_q <= res_hit_q ? mem_rdata : '0;
			out_drop_q   <= res_drop_q;
		end
	end

	rrd_slot_ram #(
		.DEPTH (SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (handle_q),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.accepted   = out_acc_q;
	assign rsp.worker     = out_wk_q;
	assign rsp.handle_out = out_handle_q;
	assign rsp.dropped    = out_drop_q;

`ifndef NO_ASSERTIONS
	// A response never both stores and drops
	a_acc_drop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.accepted && rsp.dropped))
		else $error("response both accepted and dropped");

	// A dropped push reports worker zero and no handle
	a_drop_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.dropped) |-> (rsp.worker == '0 && rsp.handle_out == '0))
		else $error("dropped push carries payload");

	// The scan never examines more rings than are in use
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (k_q < n_q && cur_q < n_q))
		else $error("ring scan out of bounds");

	// The slot memory is written only for a ring with room
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (state_q == ST_FIN && res_acc_q))
		else $error("slot write without a stored handle");
`endif

endmodule

/* rtl/core/rrd_slot_ram.sv */
// ----------------------------------------------------------------------------
// Ring slot memory
// Single write port, single registered read port, no reset on contents.
// ----------------------------------------------------------------------------
module rrd_slot_ram #(
	parameter int DEPTH = rrd_pkg::DEF_MAX_WORKERS * rrd_pkg::DEF_RING_DEPTH
) (
	input  logic                                clk,
	input  logic                                we,
	input  logic [$clog2(DEPTH)-1:0]            waddr,
	input  logic [rrd_pkg::HANDLE_W-1:0]        wdata,
	input  logic                                re,
	input  logic [$clog2(DEPTH)-1:0]            raddr,
	output logic [rrd_pkg::HANDLE_W-1:0]        rdata
);

	logic [rrd_pkg::HANDLE_W-1:0] mem_q [DEPTH];
	logic [rrd_pkg::HANDLE_W-1:0] rdata_q;

	// Store a word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Fetch a word, registered; hold it while no read is asked for
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* tb/tb_round_robin_ring_dispatcher.sv */
// ----------------------------------------------------------------------------
// Round-robin ring dispatcher testbench
// Drives push and pop requests under several worker counts, including the
// out-of-range ones. A local copy of the rings and the round-robin pointer
// predicts every response word, and each word is checked field by field.
// Both channels idle in random bursts. The response side holds off once for
// a long stretch so that the block backs up, and one phase fills a single
// ring so that pushes are dropped.
// ----------------------------------------------------------------------------
module tb_round_robin_ring_dispatcher;

	localparam int RINGS       = rrd_pkg::DEF_MAX_WORKERS;
	localparam int SLOTS       = rrd_pkg::DEF_RING_DEPTH;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_AT     = 900;
	localparam int HOLD_LEN    = 300;
	localparam int SETTLE_CYC  = 30;

	typedef struct packed {
		logic                         mode;
		logic [rrd_pkg::HANDLE_W-1:0] handle;
		logic [rrd_pkg::WORKER_W-1:0] pop_worker;
	} req_item_t;

	typedef struct packed {
		logic                         accepted;
		logic [rrd_pkg::WORKER_W-1:0] worker;
		logic [rrd_pkg::HANDLE_W-1:0] handle_out;
		logic                         dropped;
	} rsp_word_t;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_we;
	logic [rrd_pkg::CFG_W-1:0]  cfg_wdata;

	rrd_req_if req_ch ();
	rrd_rsp_if rsp_ch ();

	round_robin_ring_dispatcher i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Shadow copy of the rings, pointers and worker count
	logic [rrd_pkg::HANDLE_W-1:0] ring_mem [RINGS][SLOTS];
	int                           rd_idx [RINGS];
	int                           wr_idx [RINGS];
	int                           rr_next;
	int                           ring_cfg;

	// Request backlog, words still due, and bookkeeping
	req_item_t req_backlog [$];
	rsp_word_t due_words [$];
	req_item_t cur_req;
	bit        req_taken;
	int        reqs_queued;
	int        reqs_taken;
	int        gap_left;
	int        stall_left;
	int        hold_left;
	bit        hold_done;
	bit        calm;
	int        fault_cnt;
	int        cycle_cnt;
	int        n_stored;
	int        n_dropped;
	int        n_popped;
	int        n_empty;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Clamp the register to the number of rings that take part
	function automatic int active_rings(int cfg);
		if (cfg < 1)
			return 1;
		if (cfg > RINGS)
			return RINGS;
		return cfg;
	endfunction

	// Work out the response word for one request and update the shadow state
	function automatic rsp_word_t dispatch_outcome(req_item_t it);
		rsp_word_t o;
		int        n;
		int        start;
		int        w;
		int        nx;
		int        pw;
		bit        placed;
		o      = '0;
		placed = 1'b0;
		n      = active_rings(ring_cfg);
		if (it.mode == rrd_pkg::MODE_PUSH) begin
			start = rr_next % n;
			for (int k = 0; k < n && !placed; k++) begin
				w  = (start + k) % n;
				nx = (wr_idx[w] + 1) % SLOTS;
				if (nx != rd_idx[w]) begin
					ring_mem[w][wr_idx[w]] = it.handle;
					wr_idx[w]  = nx;
					o.accepted = 1'b1;
					o.worker   = rrd_pkg::WORKER_W'(w);
					rr_next    = (w + 1) % n;
					placed     = 1'b1;
				end
			end
			if (!placed) begin
				o.dropped = 1'b1;
				rr_next   = (start + 1) % n;
			end
		end else begin
			pw       = int'(it.pop_worker);
			o.worker = it.pop_worker;
			if (pw < n && rd_idx[pw] != wr_idx[pw]) begin
				o.handle_out = ring_mem[pw][rd_idx[pw]];
				rd_idx[pw]   = (rd_idx[pw] + 1) % SLOTS;
				o.accepted   = 1'b1;
			end
		end
		return o;
	endfunction

	task automatic add_push(logic [rrd_pkg::HANDLE_W-1:0] h);
		req_item_t it;
		it.mode       = rrd_pkg::MODE_PUSH;
		it.handle     = h;
		it.pop_worker = rrd_pkg::WORKER_W'($urandom_range(0, RINGS - 1));
		req_backlog.push_back(it);
		reqs_queued++;
	endtask

	task automatic add_pop(int w);
		req_item_t it;
		it.mode       = rrd_pkg::MODE_POP;
		it.handle     = $urandom;
		it.pop_worker = rrd_pkg::WORKER_W'(w);
		req_backlog.push_back(it);
		reqs_queued++;
	endtask

	// Wait until every queued request is taken and every word has come back
	task automatic settle();
		while (reqs_taken != reqs_queued || due_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Write the worker count while the block is idle
	task automatic set_workers(int v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= rrd_pkg::CFG_W'(v);
		@(posedge clk);
		ring_cfg = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Driver: present the next word once the current one is taken
	always @(negedge clk) begin
		if (req_taken || !req_ch.valid) begin
			req_taken = 1'b0;
			if (!arst_n || req_backlog.size() == 0) begin
				req_ch.valid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				req_ch.valid <= 1'b0;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				gap_left = $urandom_range(1, 4) - 1;
				req_ch.valid <= 1'b0;
			end else begin
				cur_req = req_backlog.pop_front();
				req_ch.valid      <= 1'b1;
				req_ch.mode       <= cur_req.mode;
				req_ch.handle_in  <= cur_req.handle;
				req_ch.pop_worker <= cur_req.pop_worker;
			end
		end
	end

	// Response side: random stalls, plus one long hold-off to back up the block
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (!hold_done && reqs_taken >= HOLD_AT) begin
			hold_done = 1'b1;
			hold_left = HOLD_LEN - 1;
			rsp_ch.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(1, 4) - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Monitor: check each response word, then log the request taken
	always @(posedge clk) begin
		rsp_word_t got;
		rsp_word_t want;
		if (rsp_ch.valid && rsp_ch.ready) begin
			got.accepted   = rsp_ch.accepted;
			got.worker     = rsp_ch.worker;
			got.handle_out = rsp_ch.handle_out;
			got.dropped    = rsp_ch.dropped;
			if (due_words.size() == 0) begin
				if (fault_cnt < 10)
					$display("ERROR: unexpected word: acc=%0b wk=%0d h=%08h drop=%0b",
						got.accepted, got.worker, got.handle_out, got.dropped);
				fault_cnt++;
			end else begin
				want = due_words.pop_front();
				if (got.accepted !== want.accepted || got.worker !== want.worker ||
					got.handle_out !== want.handle_out || got.dropped !== want.dropped) begin
					if (fault_cnt < 10) begin
						$display("ERROR: word mismatch: want acc=%0b wk=%0d h=%08h drop=%0b",
							want.accepted, want.worker, want.handle_out, want.dropped);
						$display("                        got acc=%0b wk=%0d h=%08h drop=%0b",
							got.accepted, got.worker, got.handle_out, got.dropped);
					end
					fault_cnt++;
				end
			end
		end
		if (req_ch.valid && req_ch.ready) begin
			due_words.push_back(dispatch_outcome(cur_req));
			// Tally what the run reached
			if (cur_req.mode == rrd_pkg::MODE_PUSH) begin
				if (due_words[$].accepted)
					n_stored++;
				else
					n_dropped++;
			end else if (due_words[$].accepted) begin
				n_popped++;
			end else begin
				n_empty++;
			end
			req_taken = 1'b1;
			reqs_taken++;
		end
	end

	// Watchdog: end the run if the block stops answering
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Timeout after %0d cycles, %0d words still due", cycle_cnt, due_words.size());
		$display("end of test: mismatches");
		$finish;
	end

	// Stimulus: directed cases first, then random phases over several counts
	initial begin
		int phase_cfg  [6];
		int phase_len  [6];
		int phase_push [6];
		int eff;
		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_wdata         = '0;
		req_ch.valid      = 1'b0;
		req_ch.mode       = rrd_pkg::MODE_PUSH;
		req_ch.handle_in  = '0;
		req_ch.pop_worker = '0;
		rsp_ch.ready      = 1'b0;
		ring_cfg          = int'(rrd_pkg::CFG_RESET);
		rr_next           = 0;
		for (int w = 0; w < RINGS; w++) begin
			rd_idx[w] = 0;
			wr_idx[w] = 0;
		end
		phase_cfg  = '{8, 1, 15, 3, 5, 8};
		phase_len  = '{400, 350, 300, 300, 200, 250};
		phase_push = '{55, 92, 50, 70, 30, 50};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset count: extreme handles, pops of non-empty and empty rings
		add_push(32'h0000_0000);
		add_push(32'hFFFF_FFFF);
		add_push(32'hA5A5_5A5A);
		add_push(32'h5A5A_A5A5);
		add_pop(0);
		add_pop(0);
		add_pop(3);
		add_pop(7);
		add_pop(1);
		add_pop(2);
		settle();

		// Shrink below the pointer: stale pointer wraps, pop outside the count
		set_workers(2);
		add_pop(5);
		add_push(32'h0000_0001);
		add_push(32'h8000_0000);
		add_push(32'h7FFF_FFFE);
		add_pop(0);
		add_pop(1);
		settle();

		// Zero count acts as one ring
		set_workers(0);
		add_push(32'h1234_5678);
		add_push(32'hFEDC_BA98);
		add_pop(0);
		add_pop(1);
		settle();

		// Random phases; one ring fills up under the single-ring count
		for (int p = 0; p < 6; p++) begin
			set_workers(phase_cfg[p]);
			eff = active_rings(phase_cfg[p]);
			if (p == 5)
				calm = 1'b1;
			for (int i = 0; i < phase_len[p]; i++) begin
				if ($urandom_range(0, 99) < phase_push[p])
					add_push($urandom);
				else if ($urandom_range(0, 4) == 0)
					add_pop($urandom_range(0, RINGS - 1));
				else
					add_pop($urandom_range(0, eff - 1));
			end
			settle();
		end

		if (due_words.size() != 0) begin
			$display("ERROR: %0d response words never arrived", due_words.size());
			fault_cnt++;
		end
		$display("Ran %0d requests over worker counts 0, 1, 2, 3, 5, 8 and 15 in %0d cycles",
			reqs_taken, cycle_cnt);
		$display("Pushes stored %0d, dropped %0d; pops returned %0d, empty or outside %0d",
			n_stored, n_dropped, n_popped, n_empty);
		if (fault_cnt == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
